/* hdl/clc_pkg.sv */
// ============================================================================
// clc_pkg: shared definitions for the code lock controller
// Character codes, result event codes, reset values and the result type.
// ============================================================================
`default_nettype none

package clc_pkg;

	// default code length and reset value of the attempt limit
	localparam int         CODE_LEN_DEF      = 8;
	localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd3;

	// characters with a meaning of their own
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_YES_LC     = 8'h79;
	localparam logic [7:0] CH_YES_UC     = 8'h59;
	localparam logic [7:0] CH_NO_LC      = 8'h6E;
	localparam logic [7:0] CH_NO_UC      = 8'h4E;

	// result event codes
	localparam logic [3:0] EV_ADVANCE   = 4'd0;
	localparam logic [3:0] EV_UNLOCKED  = 4'd1;
	localparam logic [3:0] EV_MISMATCH  = 4'd2;
	localparam logic [3:0] EV_LOCKOUT   = 4'd3;
	localparam logic [3:0] EV_NEWCHAR   = 4'd4;
	localparam logic [3:0] EV_PROMPT    = 4'd5;
	localparam logic [3:0] EV_CHANGED   = 4'd6;
	localparam logic [3:0] EV_DISCARDED = 4'd7;
	localparam logic [3:0] EV_IGNORED   = 4'd8;

	// one result item
	typedef struct packed {
		logic [7:0] echo_char;
		logic [3:0] event_res;
		logic [3:0] match_count;
		logic [3:0] fail_count;
	} step_res_t;

	// reset code: "stm" repeated over the code length
	function automatic logic [7:0] reset_code_char(input int idx);
		logic [7:0] ch;
		case (idx % 3)
			0:       ch = 8'h73;
			1:       ch = 8'h74;
			default: ch = 8'h6D;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

/* hdl/clc_char_if.sv */
// ============================================================================
// clc_char_if: received character channel
// Valid/ready channel that carries one received character per transfer.
// ============================================================================
`default_nettype none

interface clc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

/* hdl/clc_res_if.sv */
// ============================================================================
// clc_res_if: lock result channel
// Valid/ready channel that carries the echo, event and counters of one step.
// ============================================================================
`default_nettype none

interface clc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] echo_char;
	logic [3:0] event_res;
	logic [3:0] match_count;
	logic [3:0] fail_count;

	modport source (output valid, output echo_char, output event_res,
		output match_count, output fail_count, input ready);
	modport sink   (input valid, input echo_char, input event_res,
		input match_count, input fail_count, output ready);
endinterface

`default_nettype wire

/* hdl/code_lock_controller.sv */
// Code lock controller: takes one received character per transfer on
// char_chan and returns one result per character on result_chan (the echoed
// character, an event code and the match and failure counters after the
// step). A character passes an input register and then the lock logic, which
// updates the lock state and fills the result register, so the block takes
// one character per clock while result_chan is not stalled. The user must
// write the attempt limit through cfg_wr_en/cfg_wr_data only while no
// character is in flight; the block itself does not enforce this.
// ============================================================================
// code_lock_controller: character driven code lock, top level
// Input register, lock engine and output register with valid/ready flow.
// ============================================================================
`default_nettype none

module code_lock_controller #(
	parameter int CODE_LEN = clc_pkg::CODE_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	clc_char_if.sink        char_chan,
	clc_res_if.source       result_chan,
	input  wire logic       cfg_wr_en,
	input  wire logic [3:0] cfg_wr_data
);

	logic               in_valid_s1;
	logic [7:0]         rx_char_s1;
	logic               out_valid_s2;
	clc_pkg::step_res_t res_s2;
	clc_pkg::step_res_t step_res;
	logic [3:0]         attempt_limit_q;
	logic               advance;

	// stage 2 can take a new item when empty or being drained
	assign advance         = !out_valid_s2 || result_chan.ready;
	assign char_chan.ready = !in_valid_s1 || advance;

	// attempt limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= clc_pkg::ATTEMPT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			attempt_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (char_chan.ready) begin
			in_valid_s1 <= char_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_chan.ready && char_chan.valid) begin
			rx_char_s1 <= char_chan.rx_char;
		end
	end

	// lock logic and state
	clc_engine #(
		.CODE_LEN (CODE_LEN)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (in_valid_s1 && advance),
		.rx_char       (rx_char_s1),
		.attempt_limit (attempt_limit_q),
		.res           (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			res_s2 <= step_res;
		end
	end

	assign result_chan.valid       = out_valid_s2;
	assign result_chan.echo_char   = res_s2.echo_char;
	assign result_chan.event_res   = res_s2.event_res;
	assign result_chan.match_count = res_s2.match_count;
	assign result_chan.fail_count  = res_s2.fail_count;

endmodule

`default_nettype wire

/* hdl/clc_engine.sv */
// ============================================================================
// clc_engine: lock state and code stores
// Holds mode, positions, failure tally and both code stores, and works out
// the result and next state of one character combinationally.
// ============================================================================
`default_nettype none

module clc_engine #(
	parameter int CODE_LEN = clc_pkg::CODE_LEN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_en,
	input  wire logic [7:0]         rx_char,
	input  wire logic [3:0]         attempt_limit,
	output clc_pkg::step_res_t      res
);

	localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
	localparam int CNT_W = $clog2(CODE_LEN + 1);
	localparam logic [CNT_W-1:0] LEN_C = CNT_W'(CODE_LEN);

	// lock modes
	localparam logic [1:0] MODE_UNLOCK  = 2'd0;
	localparam logic [1:0] MODE_CHANGE  = 2'd1;
	localparam logic [1:0] MODE_CONFIRM = 2'd2;

	logic [1:0]       mode_q, mode_n, mode_eff;
	logic [CNT_W-1:0] match_pos_q, match_pos_n, match_inc;
	logic [CNT_W-1:0] new_pos_q, new_pos_n;
	logic [3:0]       fail_q, fail_n, fail_inc;
	logic [7:0]       stored_q [CODE_LEN];
	logic [7:0]       pending_q [CODE_LEN];
	logic [7:0]       want_char;
	logic             store_en, install_en;
	logic [3:0]       ev;

	// expected character at the current match position
	assign want_char = stored_q[match_pos_q[IDX_W-1:0]];
	assign match_inc = match_pos_q + CNT_W'(1);
	assign fail_inc  = fail_q + 4'd1;

	// one step of the lock
	always_comb begin
		mode_eff    = (rx_char == clc_pkg::CH_UNDERSCORE) ? MODE_CHANGE : mode_q;
		mode_n      = mode_eff;
		match_pos_n = match_pos_q;
		new_pos_n   = new_pos_q;
		fail_n      = fail_q;
		store_en    = 1'b0;
		install_en  = 1'b0;
		ev          = clc_pkg::EV_IGNORED;
		case (mode_eff)
			MODE_UNLOCK: begin
				if (match_pos_q < LEN_C && rx_char == want_char) begin
					if (match_inc >= LEN_C) begin
						match_pos_n = '0;
						new_pos_n   = '0;
						fail_n      = '0;
						mode_n      = MODE_UNLOCK;
						ev          = clc_pkg::EV_UNLOCKED;
					end else begin
						match_pos_n = match_inc;
						ev          = clc_pkg::EV_ADVANCE;
					end
				end else begin
					if (fail_inc >= attempt_limit) begin
						match_pos_n = '0;
						new_pos_n   = '0;
						fail_n      = '0;
						mode_n      = MODE_UNLOCK;
						ev          = clc_pkg::EV_LOCKOUT;
					end else begin
						fail_n = fail_inc;
						ev     = clc_pkg::EV_MISMATCH;
					end
				end
			end
			MODE_CHANGE: begin
				if (rx_char != clc_pkg::CH_UNDERSCORE && new_pos_q < LEN_C) begin
					store_en  = 1'b1;
					new_pos_n = new_pos_q + CNT_W'(1);
					ev        = clc_pkg::EV_NEWCHAR;
				end
				if (new_pos_n >= LEN_C) begin
					mode_n = MODE_CONFIRM;
					ev     = clc_pkg::EV_PROMPT;
				end
			end
			MODE_CONFIRM: begin
				if (rx_char == clc_pkg::CH_YES_LC || rx_char == clc_pkg::CH_YES_UC) begin
					install_en  = 1'b1;
					match_pos_n = '0;
					new_pos_n   = '0;
					fail_n      = '0;
					mode_n      = MODE_UNLOCK;
					ev          = clc_pkg::EV_CHANGED;
				end else if (rx_char == clc_pkg::CH_NO_LC || rx_char == clc_pkg::CH_NO_UC) begin
					match_pos_n = '0;
					new_pos_n   = '0;
					fail_n      = '0;
					mode_n      = MODE_UNLOCK;
					ev          = clc_pkg::EV_DISCARDED;
				end
			end
			default: begin
				ev = clc_pkg::EV_IGNORED;
			end
		endcase
	end

	// result of this step
	assign res.echo_char   = rx_char;
	assign res.event_res   = ev;
	assign res.match_count = 4'(match_pos_n);
	assign res.fail_count  = fail_n;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UNLOCK;
			match_pos_q <= '0;
			new_pos_q   <= '0;
			fail_q      <= '0;
		end else if (step_en) begin
			mode_q      <= mode_n;
			match_pos_q <= match_pos_n;
			new_pos_q   <= new_pos_n;
			fail_q      <= fail_n;
		end
	end

	// stored code, loaded from the pending code on confirmation
	for (genvar gi = 0; gi < CODE_LEN; gi++) begin : g_stored
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stored_q[gi] <= clc_pkg::reset_code_char(gi);
			end else if (step_en && install_en) begin
				stored_q[gi] <= pending_q[gi];
			end
		end
	end

	// pending code, one character per step in change mode
	always_ff @(posedge clk) begin
		if (step_en && store_en) begin
			pending_q[new_pos_q[IDX_W-1:0]] <= rx_char;
		end
	end

endmodule

`default_nettype wire

/* hdl/clc_checker.sv */
// ============================================================================
// clc_checker: port level checks for the code lock controller
// Checks result transfers for consistent event codes and counters.
// ============================================================================
`default_nettype none

module clc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] event_res,
	input wire logic [3:0] match_count,
	input wire logic [3:0] fail_count
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// event codes stay within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= clc_pkg::EV_IGNORED)
		else $error("undefined event code");

	// unlock, lockout, change and discard all clear progress
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == clc_pkg::EV_UNLOCKED ||
			event_res == clc_pkg::EV_LOCKOUT ||
			event_res == clc_pkg::EV_CHANGED ||
			event_res == clc_pkg::EV_DISCARDED)
		|-> match_count == 4'd0 && fail_count == 4'd0)
		else $error("progress not cleared on reset event");

	// a plain mismatch always leaves a nonzero tally
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == clc_pkg::EV_MISMATCH |-> fail_count != 4'd0)
		else $error("mismatch reported with zero tally");

	// an advance always leaves a nonzero match count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == clc_pkg::EV_ADVANCE |-> match_count != 4'd0)
		else $error("advance reported with zero match count");

endmodule

bind code_lock_controller clc_checker u_clc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_chan.valid),
	.out_ready   (result_chan.ready),
	.event_res   (result_chan.event_res),
	.match_count (result_chan.match_count),
	.fail_count  (result_chan.fail_count)
);

`default_nettype wire
